/* rtl/cts_pkg.sv */
// Shared constants and types for the closest table index search block.
// Used by cts_cell, cts_search and closest_table_index_search_top; no dependencies.
package cts_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int DATA_W      = 32;
  localparam int SIZE_W      = 5;
  localparam int SLOT_W      = 4;
  localparam int OUT_IDX_W   = 4;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(16);

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // Compare outcome of one cell against the current target.
  typedef struct packed {
    logic lt;   // target below this entry
    logic gt;   // target above this entry
    logic tie;  // target at or above the midpoint with the previous entry
  } cts_flags_t;

  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] index;
  } cts_result_t;

endpackage

/* rtl/cts_cell.sv */
// One cell of the entry chain: stores a table entry and registers its compare flags.
// Depends on cts_pkg.
module cts_cell
  import cts_pkg::*;
(
  input  logic              clk,
  input  logic              wr_en,
  input  logic [DATA_W-1:0] wr_data,
  input  logic [DATA_W-1:0] target,
  input  logic [DATA_W-1:0] prev_entry,
  output logic [DATA_W-1:0] entry,
  output cts_flags_t        flags
);

  logic [DATA_W-1:0] entry_r;
  cts_flags_t        flags_r;
  cts_flags_t        flags_nxt;
  logic [DATA_W:0]   pair_sum;

  // Twice the target against the sum of the two neighbours gives the midpoint test.
  assign pair_sum      = {1'b0, prev_entry} + {1'b0, entry_r};
  assign flags_nxt.lt  = target < entry_r;
  assign flags_nxt.gt  = target > entry_r;
  assign flags_nxt.tie = {target, 1'b0} >= pair_sum;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_r <= wr_data;
    end
    flags_r <= flags_nxt;
  end

  assign entry = entry_r;
  assign flags = flags_r;

endmodule

/* rtl/cts_search.sv */
// Halving search sequencer that walks the registered cell flags, one step a cycle.
// Depends on cts_pkg.
module cts_search
  import cts_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [CNT_W-1:0] used_cnt,
  input  cts_flags_t       flags [TABLE_DEPTH],
  output cts_result_t      res
);

  typedef enum logic [1:0] {S_IDLE, S_RANGE, S_STEP} state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] lo_r, lo_nxt;
  logic [CNT_W-1:0] hi_r, hi_nxt;
  logic             done_r, done_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  logic [CNT_W-1:0] last_cnt;
  logic [IDX_W-1:0] last_idx;
  logic [CNT_W:0]   mid_sum;
  logic [IDX_W-1:0] mid;
  logic [IDX_W-1:0] mid_up;
  logic [IDX_W-1:0] mid_dn;
  logic             found;

  assign last_cnt = used_cnt - CNT_W'(1);
  assign last_idx = last_cnt[IDX_W-1:0];
  assign mid_sum  = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid      = mid_sum[IDX_W:1];
  assign mid_up   = mid + IDX_W'(1);
  assign mid_dn   = mid - IDX_W'(1);

  always_comb begin
    state_nxt = state_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    done_nxt  = 1'b0;
    idx_nxt   = idx_r;
    found     = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_RANGE;
        end
      end
      S_RANGE: begin
        if (!flags[0].lt) begin
          done_nxt  = 1'b1;
          idx_nxt   = '0;
          state_nxt = S_IDLE;
        end else if (!flags[last_idx].gt) begin
          done_nxt  = 1'b1;
          idx_nxt   = last_idx;
          state_nxt = S_IDLE;
        end else begin
          lo_nxt    = '0;
          hi_nxt    = used_cnt;
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        if (!flags[mid].lt && !flags[mid].gt) begin
          found   = 1'b1;
          idx_nxt = mid;
        end else if (flags[mid].gt) begin
          if ((mid != '0) && flags[mid_dn].lt) begin
            found   = 1'b1;
            idx_nxt = flags[mid].tie ? mid_dn : mid;
          end else begin
            hi_nxt = CNT_W'(mid);
          end
        end else begin
          if ((CNT_W'(mid) < last_cnt) && flags[mid_up].gt) begin
            found   = 1'b1;
            idx_nxt = flags[mid_up].tie ? mid : mid_up;
          end else begin
            lo_nxt = CNT_W'(mid) + CNT_W'(1);
          end
        end
        if (!found && !(lo_nxt < hi_nxt)) begin
          found   = 1'b1;
          idx_nxt = mid;
        end
        if (found) begin
          done_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    idx_r <= idx_nxt;
  end

  assign res.done  = done_r;
  assign res.index = idx_r;

endmodule

/* rtl/closest_table_index_search_top.sv */
// Top level of the closest table index search block: stream ports, cell chain and sequencer.
// Depends on cts_pkg, cts_cell and cts_search.
//
// The block keeps a table of sixteen 32-bit entries, meant to be strictly descending, in a
// chain of cells, one entry per cell. An input item with tuser low writes its value into the
// entry named by its slot and produces no result item. An input item with
// tuser high looks up the target value and produces one result item holding the index of the
// nearest entry among the first table_size entries (a size of zero counts as one, a size above
// sixteen as sixteen). A target at or above entry 0 gives 0, a target at or below the last
// entry in use gives the last index, and a target exactly midway between two neighbours gives
// the lower index. Every cell compares the target with its own entry and with the midpoint to
// its neighbour and registers the compare flags; a halving search then walks those flags, one
// step per cycle. A lookup whose target falls outside the table ends at the range check that
// comes before the halving; any other lookup takes at most floor(log2(table_size)) + 1
// halving steps. The block handles one item at a time; it takes the next item once the result
// has moved to the output register, even while that result still waits to be taken. The table
// ordering is not checked: on an unsorted table the same search runs and gives a repeatable
// answer. Entries must be written before a lookup reaches them. table_size is written through
// cfg_we and cfg_wdata and resets to sixteen; it must be written only while the block is idle,
// which the block itself does not enforce.
module closest_table_index_search_top
  import cts_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [3:0] slot, [35:4] value, [39:36] zero
  input  logic        in_tuser,   // [0] op: 0 writes an entry, 1 looks up
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [3:0] closest_index, [7:4] zero
  // Configuration port.
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata   // table_size
);

  typedef enum logic [1:0] {T_IDLE, T_CMP, T_SEARCH, T_WAIT} state_t;

  state_t                 state_r, state_nxt;
  logic [SIZE_W-1:0]      size_r;
  logic [DATA_W-1:0]      target_r, target_nxt;
  logic                   out_tvalid_r, out_tvalid_nxt;
  logic [OUT_IDX_W-1:0]   out_idx_r, out_idx_nxt;

  logic                   in_acc;
  logic                   out_free;
  logic [SLOT_W-1:0]      in_slot;
  logic [DATA_W-1:0]      in_value;
  logic [CNT_W-1:0]       used_cnt;
  logic [DATA_W-1:0]      entry_w [TABLE_DEPTH];
  cts_flags_t             flags_w [TABLE_DEPTH];
  cts_result_t            search_res;

  assign in_slot  = in_tdata[SLOT_W-1:0];
  assign in_value = in_tdata[SLOT_W +: DATA_W];
  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_tvalid_r || out_tready;

  // Entries in use, with zero raised to one and anything beyond the table clipped.
  always_comb begin
    if (size_r == '0) begin
      used_cnt = CNT_W'(1);
    end else if (int'(size_r) > TABLE_DEPTH) begin
      used_cnt = CNT_W'(TABLE_DEPTH);
    end else begin
      used_cnt = CNT_W'(size_r);
    end
  end

  // The cell chain: each cell hands its entry on to the next for the midpoint test.
  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    logic [DATA_W-1:0] prev;
    if (k == 0) begin : g_first
      assign prev = '0;
    end else begin : g_rest
      assign prev = entry_w[k-1];
    end
    cts_cell u_cell (
      .clk        (clk),
      .wr_en      (in_acc && (in_tuser == OP_WRITE) && (int'(in_slot) == k)),
      .wr_data    (in_value),
      .target     (target_r),
      .prev_entry (prev),
      .entry      (entry_w[k]),
      .flags      (flags_w[k])
    );
  end

  cts_search u_search (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == T_CMP),
    .used_cnt (used_cnt),
    .flags    (flags_w),
    .res      (search_res)
  );

  // Sequencing of one item at a time; the output register frees the input side.
  always_comb begin
    state_nxt      = state_r;
    target_nxt     = target_r;
    out_idx_nxt    = out_idx_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    case (state_r)
      T_IDLE: begin
        if (in_acc && (in_tuser == OP_LOOKUP)) begin
          target_nxt = in_value;
          state_nxt  = T_CMP;
        end
      end
      T_CMP: begin
        state_nxt = T_SEARCH;
      end
      T_SEARCH: begin
        if (search_res.done) begin
          if (out_free) begin
            out_idx_nxt    = OUT_IDX_W'(search_res.index);
            out_tvalid_nxt = 1'b1;
            state_nxt      = T_IDLE;
          end else begin
            state_nxt = T_WAIT;
          end
        end
      end
      T_WAIT: begin
        if (out_free) begin
          out_idx_nxt    = OUT_IDX_W'(search_res.index);
          out_tvalid_nxt = 1'b1;
          state_nxt      = T_IDLE;
        end
      end
      default: begin
        state_nxt = T_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= T_IDLE;
      out_tvalid_r <= 1'b0;
      size_r       <= SIZE_RESET;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_we) begin
        size_r <= cfg_wdata;
      end
    end
    target_r  <= target_nxt;
    out_idx_r <= out_idx_nxt;
  end

  assign in_tready  = (state_r == T_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {(8 - OUT_IDX_W)'(0), out_idx_r};

`ifndef SYNTHESIS
  // The sequencer only reports a finished search while the top level waits for it.
  a_done_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    search_res.done |-> (state_r == T_SEARCH))
    else $error("search finished outside the search state");

  // The compare cycle always hands over to the search.
  a_cmp_to_search: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == T_CMP) |=> (state_r == T_SEARCH))
    else $error("compare cycle not followed by search");

  // A new result only appears at the end of a search.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && !$past(out_tvalid_r && !out_tready)) |->
      ($past(state_r == T_SEARCH) || $past(state_r == T_WAIT)))
    else $error("result item loaded without a finished search");
`endif

endmodule

/* verif/cts_index_scoreboard.sv */
`timescale 1ns / 100ps
// Scoreboard for the closest table index search testbench: shadow table, table_size copy,
// nearest-index prediction and the queue of expected result items. Depends on cts_pkg.
package cts_index_check_pkg;
  import cts_pkg::*;

  class closest_index_scoreboard;
    localparam int MAX_REPORTS = 40;

    logic [DATA_W-1:0]    entries [TABLE_DEPTH];
    logic [SIZE_W-1:0]    size_reg;
    logic [OUT_IDX_W-1:0] expected_index_q [$];
    int unsigned          writes_seen;
    int unsigned          lookups_seen;
    int unsigned          results_checked;
    int unsigned          mismatches;

    function new();
      foreach (entries[i]) entries[i] = '0;
      size_reg        = SIZE_RESET;
      writes_seen     = 0;
      lookups_seen    = 0;
      results_checked = 0;
      mismatches      = 0;
    endfunction

    function void note_size(logic [SIZE_W-1:0] value);
      size_reg = value;
    endfunction

    // A size of zero counts as one entry, anything above the depth as the full table.
    function int unsigned used_count();
      if (size_reg == 0) return 1;
      if (size_reg > TABLE_DEPTH) return TABLE_DEPTH;
      return size_reg;
    endfunction

    // Halving search for the nearest entry; a target exactly midway goes to the lower index.
    function logic [OUT_IDX_W-1:0] nearest_slot(logic [DATA_W-1:0] target);
      int unsigned n, lo, hi, m;
      n  = used_count();
      lo = 0;
      hi = n;
      m  = 0;
      if (target >= entries[0]) return '0;
      if (target <= entries[n-1]) return OUT_IDX_W'(n - 1);
      while (lo < hi) begin
        m = (lo + hi) >> 1;
        if (entries[m] == target) return OUT_IDX_W'(m);
        if (target > entries[m]) begin
          if (m > 0 && target < entries[m-1]) begin
            if (target - entries[m] >= entries[m-1] - target) return OUT_IDX_W'(m - 1);
            return OUT_IDX_W'(m);
          end
          hi = m;
        end else begin
          if (m < n - 1 && target > entries[m+1]) begin
            if (target - entries[m+1] >= entries[m] - target) return OUT_IDX_W'(m);
            return OUT_IDX_W'(m + 1);
          end
          lo = m + 1;
        end
      end
      return OUT_IDX_W'(m);
    endfunction

    // The slot field is four bits wide, so every write lands inside the table.
    function void note_item(logic op, logic [SLOT_W-1:0] slot, logic [DATA_W-1:0] value);
      if (op == OP_WRITE) begin
        entries[slot] = value;
        writes_seen++;
      end else begin
        expected_index_q.push_back(nearest_slot(value));
        lookups_seen++;
      end
    endfunction

    // The whole byte is compared, so the zero padding above the index is checked too.
    function void check_result(logic [7:0] data);
      logic [OUT_IDX_W-1:0] want;
      results_checked++;
      if (expected_index_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result item with no lookup waiting: expected none, got 0x%02h",
                   $time, data);
      end else begin
        want = expected_index_q.pop_front();
        if (data !== {4'h0, want}) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: closest_index mismatch: expected %0d, got 0x%02h",
                     $time, want, data);
        end
      end
    endfunction

    function int unsigned pending();
      return expected_index_q.size();
    endfunction
  endclass

endpackage

/* verif/tb_closest_table_index_search_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for closest_table_index_search_top: stream stimulus, random idling
// on both sides and a scoreboard check of every result. Depends on cts_pkg and cts_index_check_pkg.
module tb_closest_table_index_search_top;
  import cts_pkg::*;
  import cts_index_check_pkg::*;

  // Roughly how many input items the run offers before it winds down.
  localparam int unsigned ITEM_TARGET  = 1550;
  // Cycles allowed after the last expected result before a register write or the end.
  localparam int unsigned DRAIN_CYCLES = 12;
  // The watchdog gives up after this many cycles in which no item moves on either side.
  // The longest legitimate quiet stretch is the receiver hold-off below plus one lookup.
  localparam int unsigned STALL_LIMIT  = 2000;
  // The receiver holds off once, for this long, after this many results have been checked.
  localparam int unsigned HOLD_AFTER   = 400;
  localparam int unsigned HOLD_CYCLES  = 300;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [39:0]         in_tdata;   // [3:0] slot, [35:4] value, [39:36] zero
  logic                in_tuser;   // [0] op: 0 writes an entry, 1 looks up
  logic                out_tvalid;
  logic                out_tready;
  logic [7:0]          out_tdata;  // [3:0] closest_index, [7:4] zero
  logic                cfg_we;
  logic [SIZE_W-1:0]   cfg_wdata;  // table_size

  closest_index_scoreboard sb = new();

  // Number of further items the sender offers back to back before it next pauses.
  int unsigned burst_left;

  closest_table_index_search_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Offers one item and returns at the edge where it is taken. Within a burst the valid
  // stays high, and the next call puts fresh data on the bus in that same time step; at
  // the end of a burst the valid drops and the sender sits out a random gap.
  task automatic push_item(input logic op, input logic [SLOT_W-1:0] slot,
                           input logic [DATA_W-1:0] value);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {4'h0, value, slot};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_item(op, slot, value);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      // Now and then a long burst, so that some stretches run with no gaps at all.
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(0, 25);
    end
  endtask

  // Stops offering, waits for every expected result and then lets the block finish any
  // write still in flight, so that the block is idle on return.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Results are sampled at the rising edge, before any of that edge's updates land.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // The receiver switches between a few stall patterns of its own. Once, while the sender
  // is offering, it holds off for a long stretch so that the block fills up and has to
  // refuse further items.
  initial begin : receiver
    int unsigned mode, mode_left, hold_left, cyc;
    bit          held;
    out_tready <= 1'b0;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    cyc       = 0;
    held      = 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (!held && sb.results_checked >= HOLD_AFTER && in_tvalid) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(40, 160);
      end
      mode_left--;
      if (hold_left != 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        case (mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= 1'($urandom_range(0, 1));
          2:       out_tready <= ($urandom_range(0, 4) == 0);
          default: out_tready <= ((cyc % 7) < 3);
        endcase
      end
    end
  end

  // Any cycle in which an item moves on either side counts as progress.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no item has moved for %0d cycles", $time, STALL_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    logic [DATA_W-1:0] v, a, b, mid, start;
    logic [SIZE_W-1:0] new_size;
    int unsigned       phase, style, n, k, gap_max;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tuser   <= OP_WRITE;
    in_tdata   <= '0;
    cfg_we     <= 1'b0;
    cfg_wdata  <= '0;
    burst_left = $urandom_range(1, 30);
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset size of sixteen. The table descends evenly from 0xF0000000
    // to 0x0F000000 in steps of 0x0F000000, every entry written before any lookup.
    for (int i = 0; i < TABLE_DEPTH; i++)
      push_item(OP_WRITE, SLOT_W'(i), 32'hF000_0000 - i * 32'h0F00_0000);
    // Targets above and at entry 0, below and at the last entry.
    push_item(OP_LOOKUP, SLOT_W'($urandom), 32'hFFFF_FFFF);
    push_item(OP_LOOKUP, SLOT_W'($urandom), 32'hF000_0000);
    push_item(OP_LOOKUP, SLOT_W'($urandom), 32'h0000_0000);
    push_item(OP_LOOKUP, SLOT_W'($urandom), 32'h0F00_0000);
    // An exact hit on entry 7 and a target just above entry 10.
    push_item(OP_LOOKUP, SLOT_W'($urandom), 32'h8700_0000);
    push_item(OP_LOOKUP, SLOT_W'($urandom), 32'h5A00_0001);
    // Exactly midway between entries 3 and 4, then one below that midpoint.
    push_item(OP_LOOKUP, SLOT_W'($urandom), 32'hBB80_0000);
    push_item(OP_LOOKUP, SLOT_W'($urandom), 32'hBB7F_FFFF);
    // Exactly midway between the last two entries.
    push_item(OP_LOOKUP, SLOT_W'($urandom), 32'h1680_0000);

    // Random part, in phases. Each phase starts from an idle block with a new table_size:
    // first zero, one, 31, two, 17, the full table and three, then random sizes.
    phase = 0;
    while (sb.writes_seen + sb.lookups_seen < ITEM_TARGET) begin
      settle();
      case (phase)
        0:       new_size = 5'd0;
        1:       new_size = 5'd1;
        2:       new_size = 5'd31;
        3:       new_size = 5'd2;
        4:       new_size = 5'd17;
        5:       new_size = 5'd16;
        6:       new_size = 5'd3;
        default: new_size = ($urandom_range(0, 3) == 0) ? SIZE_W'($urandom_range(0, 31))
                                                        : SIZE_W'($urandom_range(1, 16));
      endcase
      cfg_we    <= 1'b1;
      cfg_wdata <= new_size;
      @(posedge clk);
      sb.note_size(new_size);
      cfg_we <= 1'b0;
      phase++;

      repeat ($urandom_range(2, 5)) begin
        if ($urandom_range(0, 9) < 7) begin
          // A whole new table of some shape, then lookups aimed at its entries and gaps.
          style   = $urandom_range(0, 3);
          start   = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : (32'h8000_0000 | $urandom);
          gap_max = 1 << $urandom_range(1, 27);
          v       = start;
          for (int i = 0; i < TABLE_DEPTH; i++) begin
            case (style)
              // Descending with random gaps; fifteen gaps can never run below zero.
              0: if (i != 0) v = v - $urandom_range(1, gap_max);
              // Evenly spread over the whole range, from all ones down to zero.
              1: v = 32'hFFFF_FFFF - i * 32'h1111_1111;
              // Dense small values near zero, where exact midpoints are frequent.
              2: v = 3 * (TABLE_DEPTH - 1 - i) + $urandom_range(0, 2);
              // No order at all; the search still has to give its repeatable answer.
              default: v = $urandom;
            endcase
            push_item(OP_WRITE, SLOT_W'(i), v);
          end
          repeat ($urandom_range(8, 40)) begin
            n   = sb.used_count();
            k   = $urandom_range(0, n - 1);
            a   = sb.entries[k];
            b   = (k + 1 < n) ? sb.entries[k+1] : a;
            mid = (a >= b) ? b + (a - b) / 2 : a + (b - a) / 2;
            case ($urandom_range(0, 7))
              0:       v = a;
              1:       v = a + 1;
              2:       v = a - 1;
              3, 4:    v = mid;
              5:       v = ($urandom_range(0, 1) != 0) ? mid + 1 : mid - 1;
              6:       v = $urandom;
              default: v = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0000_0000;
            endcase
            push_item(OP_LOOKUP, SLOT_W'($urandom), v);
          end
        end else begin
          // Noise: stray writes that break the ordering, mixed with random lookups.
          repeat ($urandom_range(10, 30))
            push_item(1'($urandom_range(0, 1)), SLOT_W'($urandom), $urandom);
        end
      end
    end

    settle();
    $display("Run covered %0d entry writes and %0d lookups over %0d table_size settings,",
             sb.writes_seen, sb.lookups_seen, phase);
    $display("including sizes zero, one, sixteen and oversized; %0d results checked, %0d bad.",
             sb.results_checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
